@@ design/assert_macros.svh @@
// Assertion macro used by the top-level RTL file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define AWB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ design/awb_pkg.sv @@
// Package for the white-balance gain normalizer: types, constants, divider step.
// Depends on nothing.
package awb_pkg;

    localparam int GAIN_W     = 16;
    localparam int NUM_W      = 32;
    localparam int DIV_STAGES = NUM_W;
    localparam int ST_W       = GAIN_W + NUM_W;
    localparam logic [GAIN_W-1:0] RATIO_ONE  = 16'd512;
    localparam logic [GAIN_W-1:0] UNITY_RST  = 16'd256;

    typedef enum logic [1:0] {
        MODE_GREEN = 2'd0,
        MODE_BLUE  = 2'd1,
        MODE_RED   = 2'd2
    } mode_t;

    // Item context carried alongside the dividers
    typedef struct packed {
        logic              err;
        mode_t             mode;
        logic [GAIN_W-1:0] rr;
        logic [GAIN_W-1:0] br;
        logic [GAIN_W-1:0] grn;
    } side_t;

    // One restoring division step on {remainder, numerator/quotient}
    function automatic logic [ST_W-1:0] div_step(input logic [ST_W-1:0] st,
                                                 input logic [GAIN_W-1:0] den);
        logic [GAIN_W:0]   t;
        logic              ge;
        logic [GAIN_W-1:0] rem;
        t   = {st[ST_W-1:NUM_W], st[NUM_W-1]};
        ge  = (t >= {1'b0, den});
        rem = ge ? GAIN_W'(t - {1'b0, den}) : t[GAIN_W-1:0];
        return {rem, st[NUM_W-2:0], ge};
    endfunction

endpackage

@@ design/awb_div_pipe.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on awb_pkg.
module awb_div_pipe import awb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num_a,
    input  logic [GAIN_W-1:0] den_a,
    input  logic [NUM_W-1:0]  num_b,
    input  logic [GAIN_W-1:0] den_b,
    input  side_t             side_in,
    output logic              out_valid,
    output logic [GAIN_W-1:0] quo_a,
    output logic [GAIN_W-1:0] quo_b,
    output side_t             side_out
);

    logic [ST_W-1:0]   st_a_reg  [DIV_STAGES];
    logic [ST_W-1:0]   st_b_reg  [DIV_STAGES];
    logic [GAIN_W-1:0] den_a_reg [DIV_STAGES];
    logic [GAIN_W-1:0] den_b_reg [DIV_STAGES];
    side_t             side_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_a_reg[0]  <= div_step({{GAIN_W{1'b0}}, num_a}, den_a);
            st_b_reg[0]  <= div_step({{GAIN_W{1'b0}}, num_b}, den_b);
            den_a_reg[0] <= den_a;
            den_b_reg[0] <= den_b;
            side_reg[0]  <= side_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                st_a_reg[k]  <= div_step(st_a_reg[k-1], den_a_reg[k-1]);
                st_b_reg[k]  <= div_step(st_b_reg[k-1], den_b_reg[k-1]);
                den_a_reg[k] <= den_a_reg[k-1];
                den_b_reg[k] <= den_b_reg[k-1];
                side_reg[k]  <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quo_a     = st_a_reg[DIV_STAGES-1][GAIN_W-1:0];
    assign quo_b     = st_b_reg[DIV_STAGES-1][GAIN_W-1:0];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

@@ design/awb_gain_select.sv @@
// Picks the unity channel, flags zero divisors, forms the final numerators.
// Depends on awb_pkg.
module awb_gain_select import awb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [GAIN_W-1:0] unity,
    input  logic              in_valid,
    input  side_t             side_in,
    input  logic [GAIN_W-1:0] gr,
    input  logic [GAIN_W-1:0] gb,
    output logic              out_valid,
    output logic [NUM_W-1:0]  num_a,
    output logic [GAIN_W-1:0] den_a,
    output logic [NUM_W-1:0]  num_b,
    output logic [GAIN_W-1:0] den_b,
    output side_t             side_out
);

    side_t sel_next, sel_reg, prod_reg;
    logic  sel_valid_reg, prod_valid_reg;
    logic  r_hi, b_hi;
    logic [NUM_W-1:0]  num_a_reg, num_b_reg;
    logic [GAIN_W-1:0] den_a_reg, den_b_reg;

    always_comb begin
        r_hi     = side_in.rr >= RATIO_ONE;
        b_hi     = side_in.br >= RATIO_ONE;
        sel_next = side_in;
        if (r_hi && b_hi) begin
            sel_next.mode = MODE_GREEN;
        end else if (r_hi) begin
            sel_next.mode = MODE_BLUE;
        end else if (b_hi) begin
            sel_next.mode = MODE_RED;
        end else begin
            sel_next.mode = (gr >= gb) ? MODE_RED : MODE_BLUE;
            if (side_in.rr == '0 || side_in.br == '0) begin
                sel_next.err = 1'b1;
            end
        end
        if (sel_next.mode == MODE_BLUE && side_in.br == '0) begin
            sel_next.err = 1'b1;
        end
        if (sel_next.mode == MODE_RED && side_in.rr == '0) begin
            sel_next.err = 1'b1;
        end
        unique case (sel_next.mode)
            MODE_BLUE: sel_next.grn = gb;
            MODE_RED:  sel_next.grn = gr;
            default:   sel_next.grn = unity;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else if (en) begin
            sel_valid_reg  <= in_valid;
            prod_valid_reg <= sel_valid_reg;
        end
    end

    // Unit numerator/denominator pass the unity code straight through
    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg  <= sel_next;
            prod_reg <= sel_reg;
            unique case (sel_reg.mode)
                MODE_BLUE: begin
                    num_a_reg <= unity * sel_reg.rr;
                    den_a_reg <= sel_reg.br;
                    num_b_reg <= NUM_W'(unity);
                    den_b_reg <= 16'd1;
                end
                MODE_RED: begin
                    num_a_reg <= NUM_W'(unity);
                    den_a_reg <= 16'd1;
                    num_b_reg <= unity * sel_reg.br;
                    den_b_reg <= sel_reg.rr;
                end
                default: begin
                    num_a_reg <= unity * sel_reg.rr;
                    den_a_reg <= RATIO_ONE;
                    num_b_reg <= unity * sel_reg.br;
                    den_b_reg <= RATIO_ONE;
                end
            endcase
        end
    end

    assign out_valid = prod_valid_reg;
    assign num_a     = num_a_reg;
    assign den_a     = den_a_reg;
    assign num_b     = num_b_reg;
    assign den_b     = den_b_reg;
    assign side_out  = prod_reg;

endmodule

@@ design/awb_gain_normalizer.sv @@
// White-balance gain normalizer top level: config register, pipeline, output.
// Depends on awb_pkg, awb_div_pipe, awb_gain_select, assert_macros.svh.
//
// Usage:
//   s_ channel carries measured_rg/bg and golden_rg/bg; m_ channel returns
//   red, green and blue gain codes plus divide_error, one result per item.
//   cfg_ channel writes unity_gain (reset 256); write it only when idle.
//   A 32-stage divider forms both ratios, a second 32-stage divider forms
//   the implied green gains, a select register picks the unity channel and
//   a product register forms the products, a third 32-stage divider forms the
//   final gains, and one output register holds the result.
//   One item per cycle is accepted unless the output stalls; each divider
//   stage retires one quotient bit per cycle when not stalled.
//   The whole pipeline advances together: while m_valid is high and
//   m_ready low, s_ready drops and every stage holds its item.
//   Reset clears all valid bits and loads unity_gain with 256.
`include "assert_macros.svh"
module awb_gain_normalizer import awb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GAIN_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [GAIN_W-1:0] s_measured_rg,
    input  logic [GAIN_W-1:0] s_measured_bg,
    input  logic [GAIN_W-1:0] s_golden_rg,
    input  logic [GAIN_W-1:0] s_golden_bg,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [GAIN_W-1:0] m_red_gain,
    output logic [GAIN_W-1:0] m_green_gain,
    output logic [GAIN_W-1:0] m_blue_gain,
    output logic              m_divide_error
);

    logic [GAIN_W-1:0] unity_reg;
    logic              en;
    side_t             side0, side1_out, side2_in, side2_out, side3_in, side3_out;
    logic              v1, v2, v3s, v3;
    logic [GAIN_W-1:0] rr, br, gr, gb, red_q, blu_q;
    logic [NUM_W-1:0]  n3a, n3b;
    logic [GAIN_W-1:0] d3a, d3b;
    logic              m_valid_reg;
    logic [GAIN_W-1:0] red_reg, grn_reg, blu_reg;
    logic              err_reg;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unity_reg <= UNITY_RST;
        end else if (cfg_valid) begin
            unity_reg <= cfg_wdata;
        end
    end

    always_comb begin
        side0      = '0;
        side0.mode = MODE_GREEN;
        side0.err  = (s_measured_rg == '0) || (s_measured_bg == '0);
    end

    awb_div_pipe u_ratio_div (
        .aclk, .aresetn, .en,
        .in_valid (s_valid && s_ready),
        .num_a    ({7'b0, s_golden_rg, 9'b0}),
        .den_a    (s_measured_rg),
        .num_b    ({7'b0, s_golden_bg, 9'b0}),
        .den_b    (s_measured_bg),
        .side_in  (side0),
        .out_valid(v1),
        .quo_a    (rr),
        .quo_b    (br),
        .side_out (side1_out)
    );

    always_comb begin
        side2_in    = side1_out;
        side2_in.rr = rr;
        side2_in.br = br;
    end

    awb_div_pipe u_green_div (
        .aclk, .aresetn, .en,
        .in_valid (v1),
        .num_a    ({7'b0, unity_reg, 9'b0}),
        .den_a    (rr),
        .num_b    ({7'b0, unity_reg, 9'b0}),
        .den_b    (br),
        .side_in  (side2_in),
        .out_valid(v2),
        .quo_a    (gr),
        .quo_b    (gb),
        .side_out (side2_out)
    );

    awb_gain_select u_select (
        .aclk, .aresetn, .en,
        .unity    (unity_reg),
        .in_valid (v2),
        .side_in  (side2_out),
        .gr,
        .gb,
        .out_valid(v3s),
        .num_a    (n3a),
        .den_a    (d3a),
        .num_b    (n3b),
        .den_b    (d3b),
        .side_out (side3_in)
    );

    awb_div_pipe u_gain_div (
        .aclk, .aresetn, .en,
        .in_valid (v3s),
        .num_a    (n3a),
        .den_a    (d3a),
        .num_b    (n3b),
        .den_b    (d3b),
        .side_in  (side3_in),
        .out_valid(v3),
        .quo_a    (red_q),
        .quo_b    (blu_q),
        .side_out (side3_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v3;
        end
    end

    // Zero all gains on a divide error
    always_ff @(posedge aclk) begin
        if (en) begin
            err_reg <= side3_out.err;
            red_reg <= side3_out.err ? '0 : red_q;
            grn_reg <= side3_out.err ? '0 : side3_out.grn;
            blu_reg <= side3_out.err ? '0 : blu_q;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red_gain     = red_reg;
    assign m_green_gain   = grn_reg;
    assign m_blue_gain    = blu_reg;
    assign m_divide_error = err_reg;

    `AWB_ASSERT(a_err_zero, aclk, aresetn, (m_valid && m_divide_error) |-> (m_red_gain == '0 && m_green_gain == '0 && m_blue_gain == '0), "divide error with nonzero gain")
    `AWB_ASSERT(a_unity_chan, aclk, aresetn, (m_valid && !m_divide_error && !cfg_valid) |-> (m_red_gain == unity_reg || m_green_gain == unity_reg || m_blue_gain == unity_reg), "no channel at unity gain")
    `AWB_ASSERT(a_stall_hold, aclk, aresetn, (!s_ready) |-> (m_valid && !m_ready), "input stalled without output back-pressure")

endmodule
